/* hdl/clcd_pkg.sv */
package clcd_pkg;

    // Display geometry and number formatting
    localparam int LINE_LENGTH = 16;
    localparam int MAX_DIGITS  = 10;
    localparam int NUM_W       = 31;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int LEFT_W      = $clog2(MAX_DIGITS + 1);

    // Expander and controller constants
    localparam logic [7:0] EXP_ADDR_RESET = 8'd78;
    localparam logic [7:0] ROW1_BASE      = 8'h40;
    localparam logic [7:0] ROW2_BASE      = 8'h10;
    localparam logic [7:0] ROW3_BASE      = 8'h50;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // Request codes
    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_CMD    = 2'd1,
        OP_CURSOR = 2'd2,
        OP_NUMBER = 2'd3
    } t_op;

    // Shift-and-add-3 correction of one BCD digit
    function automatic logic [3:0] f_dabble_adj(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

endpackage

/* hdl/clcd_dabble.sv */
// Bit-serial binary to BCD converter, one input bit per cycle
module clcd_dabble
    import clcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_value,
    output logic             o_done,
    output logic [BCD_W-1:0] o_bcd
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] adj;

    // Per-digit add-3 correction before each shift
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_adj
        assign adj[4*g +: 4] = f_dabble_adj(r_bcd[4*g +: 4]);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_run) begin
            r_bin <= {r_bin[NUM_W-2:0], 1'b0};
            r_bcd <= {adj[BCD_W-2:0], r_bin[NUM_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

`ifndef SYNTHESIS
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_run)
        else $error("converter did not start");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done longer than one cycle");
    a_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && !i_start && r_cnt == '0) |=> (o_done && !r_run))
        else $error("conversion did not finish after last bit");
`endif

endmodule

/* hdl/char_lcd_expander_nibble_sequencer.sv */
// Turns display requests into expander frames for a 4-bit character display.
// Character, command and cursor requests give one result in the cycle after
// start is taken, and busy stays low, so one of these may be issued every
// cycle. A number request raises busy while the bit-serial BCD converter
// runs (31 shifts, one bit of the number per cycle, then the hand-over of
// the digits), while the scan drops each suppressed leading zero and then
// leaves, and while the digits go out at one result per cycle; suppressed
// zeros and printed digits always add up to ten. The last digit is on the
// outputs in the same cycle that busy falls. Results appear on o_strobe for
// a single cycle and cannot be held off. The configuration channel is always
// ready; write it only while busy is low and no result is pending.
module char_lcd_expander_nibble_sequencer
    import clcd_pkg::*;
#(
    parameter int P_LINE_LENGTH = LINE_LENGTH
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_byte_value,
    input  logic [2:0]       i_row,
    input  logic [7:0]       i_column,
    input  logic [NUM_W-1:0] i_number_value,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data,
    output logic             o_strobe,
    output logic [7:0]       o_target_address,
    output logic [7:0]       o_frame_0,
    output logic [7:0]       o_frame_1,
    output logic [7:0]       o_frame_2,
    output logic [7:0]       o_frame_3,
    output logic [7:0]       o_frame_4,
    output logic [7:0]       o_frame_5,
    output logic [7:0]       o_frame_6,
    output logic             o_last_of_run
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic                r_strobe, n_strobe;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [BCD_W-1:0]    r_digits, n_digits;
    logic                r_rs, n_rs;
    logic [7:0]          r_val, n_val;
    logic                r_last, n_last;
    logic [7:0]          r_addr, n_addr;
    logic [7:0]          r_exp_addr;

    logic                accept;
    logic                conv_start;
    logic                conv_done;
    logic [BCD_W-1:0]    conv_bcd;
    logic [7:0]          row_base;
    logic [7:0]          cur_addr;
    logic [7:0]          cur_cmd;
    logic [3:0]          top_digit;
    t_op                 op;

    assign op         = t_op'(i_op);
    assign accept     = start && !busy;
    assign conv_start = accept && (op == OP_NUMBER);
    assign top_digit  = r_digits[BCD_W-1 -: 4];

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= EXP_ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exp_addr <= i_cfg_data;
        end
    end

    // Decimal digit source
    clcd_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_value (i_number_value),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // Cursor address command
    always_comb begin
        unique case (i_row)
            3'd1:    row_base = ROW1_BASE;
            3'd2:    row_base = ROW2_BASE;
            3'd3:    row_base = ROW3_BASE;
            default: row_base = 8'h00;
        endcase
        cur_addr = row_base + ((i_column <= 8'(P_LINE_LENGTH)) ? i_column : 8'h00);
        cur_cmd  = CMD_SET_DDRAM | {1'b0, cur_addr[6:0]};
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_left   = r_left;
        n_digits = r_digits;
        n_rs     = r_rs;
        n_val    = r_val;
        n_last   = r_last;
        n_addr   = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (op == OP_NUMBER) begin
                        n_state = S_CONV;
                    end else begin
                        n_strobe = 1'b1;
                        n_rs     = (op == OP_CHAR);
                        n_val    = (op == OP_CURSOR) ? cur_cmd : i_byte_value;
                        n_last   = 1'b1;
                        n_addr   = r_exp_addr;
                    end
                end
            end
            S_CONV: begin
                if (conv_done) begin
                    n_digits = conv_bcd;
                    n_left   = LEFT_W'(MAX_DIGITS);
                    n_state  = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, always keep the final digit
                if (r_left > LEFT_W'(1) && top_digit == 4'd0) begin
                    n_digits = {r_digits[BCD_W-5:0], 4'd0};
                    n_left   = r_left - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_rs     = 1'b1;
                n_val    = ASCII_ZERO | {4'd0, top_digit};
                n_last   = (r_left == LEFT_W'(1));
                n_addr   = r_exp_addr;
                n_digits = {r_digits[BCD_W-5:0], 4'd0};
                n_left   = r_left - 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_left   <= n_left;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_rs     <= n_rs;
        r_val    <= n_val;
        r_last   <= n_last;
        r_addr   <= n_addr;
    end

    // Frame build: high nibble strobe, then low nibble strobe
    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_target_address = r_addr;
    assign o_frame_0        = {4'h0, 1'b1, 1'b0, 1'b0, r_rs};
    assign o_frame_1        = {4'h0, 1'b1, 1'b1, 1'b0, r_rs};
    assign o_frame_2        = {r_val[7:4], 1'b1, 1'b1, 1'b0, r_rs};
    assign o_frame_3        = {r_val[7:4], 1'b1, 1'b0, 1'b0, r_rs};
    assign o_frame_4        = {r_val[7:4], 1'b1, 1'b1, 1'b0, r_rs};
    assign o_frame_5        = {r_val[3:0], 1'b1, 1'b1, 1'b0, r_rs};
    assign o_frame_6        = {r_val[3:0], 1'b1, 1'b0, 1'b0, r_rs};
    assign o_last_of_run    = r_last;

`ifndef SYNTHESIS
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op != OP_NUMBER) |=> (o_strobe && o_last_of_run))
        else $error("single-byte request gave no final result");
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (top_digit <= 4'd9))
        else $error("emitted digit is not decimal");
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_of_run) |=> o_strobe)
        else $error("digit run broken before its last result");
    a_run_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_left == LEFT_W'(1)) |=> (!busy && o_last_of_run))
        else $error("number run did not end on its last digit");
`endif

endmodule

/* bench/char_lcd_expander_nibble_sequencer_tb.sv */
`timescale 1ns / 1ps

module char_lcd_expander_nibble_sequencer_tb;

    import clcd_pkg::t_op;
    import clcd_pkg::OP_CHAR;
    import clcd_pkg::OP_CMD;
    import clcd_pkg::OP_CURSOR;
    import clcd_pkg::OP_NUMBER;
    import clcd_pkg::NUM_W;

    // Expander byte layout and display controller constants
    localparam logic [7:0] CTRL_RS_DATA   = 8'h09;
    localparam logic [7:0] CTRL_RS_CMD    = 8'h08;
    localparam logic [7:0] EN_MASK        = 8'h04;
    localparam logic [7:0] EN_CLEAR_MASK  = 8'hFB;
    localparam logic [7:0] LINE1_BASE     = 8'h40;
    localparam logic [7:0] LINE2_BASE     = 8'h10;
    localparam logic [7:0] LINE3_BASE     = 8'h50;
    localparam logic [7:0] SET_DDRAM_CMD  = 8'h80;
    localparam logic [7:0] DIGIT_ZERO     = 8'h30;
    localparam int         LINE_LEN       = 16;
    localparam int         DIGITS_MAX     = 10;
    localparam logic [7:0] ADDR_AT_RESET  = 8'd78;

    localparam int CLK_HALF_NS     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 60;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        t_op               op;
        logic [7:0]        byte_value;
        logic [2:0]        row;
        logic [7:0]        column;
        logic [NUM_W-1:0]  number_value;
    } lcd_request_t;

    typedef struct packed {
        logic [7:0] target_address;
        logic [7:0] f0;
        logic [7:0] f1;
        logic [7:0] f2;
        logic [7:0] f3;
        logic [7:0] f4;
        logic [7:0] f5;
        logic [7:0] f6;
        logic       last_of_run;
    } lcd_frame_t;

    // DUT signals
    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             start            = 1'b0;
    logic             busy;
    logic [1:0]       i_op             = '0;
    logic [7:0]       i_byte_value     = '0;
    logic [2:0]       i_row            = '0;
    logic [7:0]       i_column         = '0;
    logic [NUM_W-1:0] i_number_value   = '0;
    logic             i_cfg_valid      = 1'b0;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data       = '0;
    logic             o_strobe;
    logic [7:0]       o_target_address;
    logic [7:0]       o_frame_0;
    logic [7:0]       o_frame_1;
    logic [7:0]       o_frame_2;
    logic [7:0]       o_frame_3;
    logic [7:0]       o_frame_4;
    logic [7:0]       o_frame_5;
    logic [7:0]       o_frame_6;
    logic             o_last_of_run;

    // Bench state
    lcd_request_t  request_q[$];
    lcd_frame_t    pending_lcd_frames[$];
    logic [7:0]    model_exp_addr = ADDR_AT_RESET;
    int            send_idle_pct  = 0;
    int            mismatch_count = 0;
    int            stall_cycles   = 0;

    char_lcd_expander_nibble_sequencer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_byte_value     (i_byte_value),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_number_value   (i_number_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_target_address (o_target_address),
        .o_frame_0        (o_frame_0),
        .o_frame_1        (o_frame_1),
        .o_frame_2        (o_frame_2),
        .o_frame_3        (o_frame_3),
        .o_frame_4        (o_frame_4),
        .o_frame_5        (o_frame_5),
        .o_frame_6        (o_frame_6),
        .o_last_of_run    (o_last_of_run)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // One display byte as the seven-byte enable strobe sequence
    function automatic lcd_frame_t nibble_frame(input logic is_data, input logic [7:0] value,
                                                input logic last);
        lcd_frame_t fr;
        fr.target_address = model_exp_addr;
        fr.f0 = is_data ? CTRL_RS_DATA : CTRL_RS_CMD;
        fr.f1 = fr.f0 | EN_MASK;
        fr.f2 = fr.f1 | (value & 8'hF0);
        fr.f3 = fr.f2 & EN_CLEAR_MASK;
        fr.f4 = fr.f3 | EN_MASK;
        fr.f5 = (fr.f4 & 8'h0F) | {value[3:0], 4'h0};
        fr.f6 = fr.f5 & EN_CLEAR_MASK;
        fr.last_of_run = last;
        return fr;
    endfunction

    // Expands one accepted request into the frames it should produce
    function automatic void expand_request_to_frames(input lcd_request_t req);
        logic [7:0]  ddram;
        int unsigned n;
        int unsigned digits[DIGITS_MAX];
        int          cnt;
        case (req.op)
            OP_CHAR: pending_lcd_frames.push_back(nibble_frame(1'b1, req.byte_value, 1'b1));
            OP_CMD:  pending_lcd_frames.push_back(nibble_frame(1'b0, req.byte_value, 1'b1));
            OP_CURSOR: begin
                case (req.row)
                    3'd1:    ddram = LINE1_BASE;
                    3'd2:    ddram = LINE2_BASE;
                    3'd3:    ddram = LINE3_BASE;
                    default: ddram = 8'h00;   // rows 4..7 fall back to line 0
                endcase
                // out-of-range column leaves the line base alone
                if (req.column <= LINE_LEN) ddram = ddram + req.column;
                pending_lcd_frames.push_back(
                    nibble_frame(1'b0, SET_DDRAM_CMD | {1'b0, ddram[6:0]}, 1'b1));
            end
            default: begin
                n = req.number_value;
                cnt = 0;
                while (n != 0 && cnt < DIGITS_MAX) begin
                    digits[cnt] = n % 10;
                    n = n / 10;
                    cnt++;
                end
                if (cnt == 0) begin
                    pending_lcd_frames.push_back(nibble_frame(1'b1, DIGIT_ZERO, 1'b1));
                end else begin
                    for (int k = 0; k < cnt; k++)
                        pending_lcd_frames.push_back(nibble_frame(1'b1,
                            DIGIT_ZERO + 8'(digits[cnt - 1 - k]), k == cnt - 1));
                end
            end
        endcase
    endfunction

    function automatic void log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
            log_failure($sformatf("%s mismatch: expected %02h, got %02h", name, want, got));
    endfunction

    // Request driver: presents queued requests, idles at random, noise on idle fields
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expand_request_to_frames(request_q.pop_front());
            if (start && busy) begin
                // hold the current request until it is taken
            end else if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                start          <= 1'b1;
                i_op           <= request_q[0].op;
                i_byte_value   <= request_q[0].byte_value;
                i_row          <= request_q[0].row;
                i_column       <= request_q[0].column;
                i_number_value <= request_q[0].number_value;
            end else begin
                start          <= 1'b0;
                i_op           <= 2'($urandom_range(3));
                i_byte_value   <= 8'($urandom);
                i_row          <= 3'($urandom);
                i_column       <= 8'($urandom);
                i_number_value <= NUM_W'($urandom);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        lcd_frame_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_lcd_frames.size() == 0) begin
                log_failure("frame strobe with no display byte outstanding");
            end else begin
                want = pending_lcd_frames.pop_front();
                check_field("target_address", want.target_address, o_target_address);
                check_field("frame_0", want.f0, o_frame_0);
                check_field("frame_1", want.f1, o_frame_1);
                check_field("frame_2", want.f2, o_frame_2);
                check_field("frame_3", want.f3, o_frame_3);
                check_field("frame_4", want.f4, o_frame_4);
                check_field("frame_5", want.f5, o_frame_5);
                check_field("frame_6", want.f6, o_frame_6);
                check_field("last_of_run", 8'(want.last_of_run), 8'(o_last_of_run));
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_request(input t_op op, input logic [7:0] byte_value,
                                input logic [2:0] row, input logic [7:0] column,
                                input logic [NUM_W-1:0] number_value);
        lcd_request_t req;
        req.op           = op;
        req.byte_value   = byte_value;
        req.row          = row;
        req.column       = column;
        req.number_value = number_value;
        while (request_q.size() >= 2) @(negedge i_clk);
        request_q.push_back(req);
    endtask

    // Returns at a rising edge once the block is idle and nothing is outstanding
    task automatic wait_drained();
        do @(posedge i_clk);
        while (request_q.size() != 0 || start || busy || pending_lcd_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Call only right after wait_drained or reset release
    task automatic write_expander_address(input logic [7:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_exp_addr = addr;
        i_cfg_valid <= 1'b0;
    endtask

    // Field extremes, every request type, cursor corner cases
    task automatic test_directed_requests();
        send_idle_pct = 0;
        send_request(OP_CHAR,   8'h00, 3'd0, 8'd0,   '0);
        send_request(OP_CHAR,   8'hFF, 3'd7, 8'd255, '1);
        send_request(OP_CHAR,   8'hA5, 3'd0, 8'd0,   '0);
        send_request(OP_CMD,    8'h00, 3'd0, 8'd0,   '0);
        send_request(OP_CMD,    8'hFF, 3'd0, 8'd0,   '0);
        send_request(OP_CMD,    8'h5A, 3'd0, 8'd0,   '0);
        for (int r = 0; r < 8; r++)
            send_request(OP_CURSOR, 8'h00, 3'(r), 8'(r + 3), '0);
        send_request(OP_CURSOR, 8'hFF, 3'd3, 8'd16,  '0);  // largest in-range address
        send_request(OP_CURSOR, 8'h00, 3'd1, 8'd17,  '0);  // column just past the line
        send_request(OP_CURSOR, 8'h00, 3'd2, 8'd255, '0);
        send_request(OP_CURSOR, 8'h00, 3'd0, 8'd0,   '1);
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0,   '0);  // zero prints a single digit
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0,   31'd9);
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0,   31'd10);
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0,   31'd1000000000);
        send_request(OP_NUMBER, 8'hFF, 3'd7, 8'd255, '1);  // ten digits
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0,   31'd999999999);
        wait_drained();
    endtask

    // Expander address register at its extremes and back at its reset value
    task automatic test_address_register();
        send_idle_pct = 28;
        write_expander_address(8'h00);
        send_request(OP_CHAR,   8'h41, 3'd0, 8'd0, '0);
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0, 31'd4096);
        wait_drained();
        write_expander_address(8'hFF);
        send_request(OP_CMD,    8'h01, 3'd0, 8'd0, '0);
        send_request(OP_CURSOR, 8'h00, 3'd2, 8'd5, '0);
        wait_drained();
        write_expander_address(ADDR_AT_RESET);
        send_request(OP_NUMBER, 8'h00, 3'd0, 8'd0, 31'd77);
        wait_drained();
    endtask

    // Random requests; now and then the sender waits until all frames are back
    task automatic test_random_traffic(input int idle_pct, input int count);
        int unsigned limit;
        logic [NUM_W-1:0] num;
        logic [7:0] col;
        send_idle_pct = idle_pct;
        write_expander_address(8'($urandom));
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0:       num = NUM_W'($urandom);
                1:       num = NUM_W'($urandom_range(9));
                default: begin
                    limit = 10;
                    repeat ($urandom_range(8)) limit = limit * 10;
                    num = NUM_W'($urandom_range(limit - 1));
                end
            endcase
            col = $urandom_range(1) ? 8'($urandom_range(LINE_LEN + 2)) : 8'($urandom);
            send_request(t_op'($urandom_range(3)), 8'($urandom), 3'($urandom), col, num);
            if ($urandom_range(39) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_requests();
        test_address_register();
        test_random_traffic(28, 100);
        test_random_traffic(67, 100);
        test_random_traffic(0, 100);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_lcd_frames.size() != 0)
            log_failure($sformatf("%0d display bytes never arrived", pending_lcd_frames.size()));
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
